[rtl/core/tspr_pkg.sv]
// Package for the two-segment page replacement core.
// Holds the page width, the status codes and the result record shared by all files but tspr_ram.
// No dependencies.
`default_nettype none

package tspr_pkg;

  localparam int unsigned PageW = 16;

  typedef enum logic [2:0] {
    ST_COLD_APPEND   = 3'd0,
    ST_HOT_PUSH      = 3'd1,
    ST_COLD_REPLACE  = 3'd2,
    ST_PROMOTED      = 3'd3,
    ST_NULL          = 3'd4,
    ST_COLD_NOT_FULL = 3'd5,
    ST_HOT_FULL      = 3'd6
  } status_e;

  typedef enum logic {
    ACT_INSERT  = 1'b0,
    ACT_PROMOTE = 1'b1
  } action_e;

  typedef struct packed {
    status_e          status;
    logic             evicted_valid;
    logic [PageW-1:0] evicted_page;
    logic             found_in_cold;
  } rslt_t;

endpackage

`default_nettype wire

[rtl/core/tspr_if.sv]
// Valid/ready channel interfaces for the request and response transactions.
// Depends on tspr_pkg for the page width.
`default_nettype none

interface tspr_req_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic                       page_absent;
  logic [tspr_pkg::PageW-1:0] page_id;

  modport source (output valid, action, page_absent, page_id, input ready);
  modport sink   (input valid, action, page_absent, page_id, output ready);
endinterface

interface tspr_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [2:0]                 status;
  logic                       evicted_valid;
  logic [tspr_pkg::PageW-1:0] evicted_page;
  logic                       found_in_cold;

  modport source (output valid, status, evicted_valid, evicted_page, found_in_cold,
                  input ready);
  modport sink   (input valid, status, evicted_valid, evicted_page, found_in_cold,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/two_segment_page_replacement_core.sv]
// Top level of the two-segment (cold/hot) page replacement core.
// Depends on tspr_pkg, tspr_if and tspr_ctrl.
//
//   Channel  Dir  Handshake          Payload
//   req_i    in   valid/ready        action, page_absent, page_id
//   rsp_o    out  valid/ready        status, evicted_valid, evicted_page, found_in_cold
//
// One transaction at a time: null, rejected and cold-append requests need no sweep, a hot
// push sweeps the hot list, a cold replace the cold list, and a promote the cold list and
// then the hot list. The work is done by the single sweep unit that moves one list entry
// per cycle through the page memory ports.
// Reset clears both list counts; the list memories are not cleared.
// A full response register lets one result wait while the next request is accepted.
`default_nettype none

module two_segment_page_replacement_core #(
  parameter int unsigned COLD_DEPTH = 8,
  parameter int unsigned HOT_DEPTH  = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tspr_req_if.sink   req_i,
  tspr_rsp_if.source rsp_o
);
  import tspr_pkg::*;

  logic  rslt_valid, rslt_ready, load;
  rslt_t rslt;
  logic  rsp_valid_q, rsp_valid_d;
  rslt_t rsp_q;

  tspr_ctrl #(.COLD_DEPTH(COLD_DEPTH), .HOT_DEPTH(HOT_DEPTH)) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .req_ready_o   (req_i.ready),
    .action_i      (req_i.action),
    .page_absent_i (req_i.page_absent),
    .page_id_i     (req_i.page_id),
    .rslt_valid_o  (rslt_valid),
    .rslt_ready_i  (rslt_ready),
    .rslt_o        (rslt)
  );

  assign rslt_ready = !rsp_valid_q || rsp_o.ready;
  assign load       = rslt_valid && rslt_ready;

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rsp_q <= rslt;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = rsp_q.status;
  assign rsp_o.evicted_valid = rsp_q.evicted_valid;
  assign rsp_o.evicted_page  = rsp_q.evicted_page;
  assign rsp_o.found_in_cold = rsp_q.found_in_cold;

endmodule

`default_nettype wire

[rtl/core/tspr_ram.sv]
// Simple dual-port page memory: one write port and one registered read port.
// No dependencies.
`default_nettype none

module tspr_ram #(
  parameter int unsigned Depth = 8,
  parameter int unsigned Width = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/tspr_ctrl.sv]
// Sequencer of the page replacement core: one read/compare/write sweep unit
// shared by the cold list and the hot list, plus the list counts.
// Depends on tspr_pkg and tspr_ram.
`default_nettype none

module tspr_ctrl #(
  parameter int unsigned COLD_DEPTH = 8,
  parameter int unsigned HOT_DEPTH  = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  output logic                       req_ready_o,
  input  logic                       action_i,
  input  logic                       page_absent_i,
  input  logic [tspr_pkg::PageW-1:0] page_id_i,
  output logic                       rslt_valid_o,
  input  logic                       rslt_ready_i,
  output tspr_pkg::rslt_t            rslt_o
);
  import tspr_pkg::*;

  localparam int unsigned MaxD   = (COLD_DEPTH > HOT_DEPTH) ? COLD_DEPTH : HOT_DEPTH;
  localparam int unsigned CAW    = (COLD_DEPTH > 1) ? $clog2(COLD_DEPTH) : 1;
  localparam int unsigned HAW    = (HOT_DEPTH > 1) ? $clog2(HOT_DEPTH) : 1;
  localparam int unsigned AW     = (MaxD > 1) ? $clog2(MaxD) : 1;
  localparam int unsigned CCW    = $clog2(COLD_DEPTH + 1);
  localparam int unsigned HCW    = $clog2(HOT_DEPTH + 1);
  localparam int unsigned RW     = $clog2(MaxD + 1);
  localparam int unsigned ColdLo = (COLD_DEPTH >= 2) ? 1 : 0;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SWEEP = 4'b0010,
    S_FINAL = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_COLD_APPEND,
    OP_HOT_PUSH,
    OP_COLD_REPLACE,
    OP_PROMOTE
  } op_e;

  state_e           state_q, state_d;
  op_e              op_q, op_d;
  logic [PageW-1:0] id_q, id_d;
  logic             sel_hot_q, sel_hot_d;
  logic             down_q, down_d;
  logic [AW-1:0]    rd_idx_q, rd_idx_d;
  logic [RW-1:0]    rem_q, rem_d;
  logic             rv_q, rv_d;
  logic [AW-1:0]    ra_q, ra_d;
  logic [CCW-1:0]   w_q, w_d;
  logic [CCW-1:0]   cold_cnt_q, cold_cnt_d;
  logic [HCW-1:0]   hot_cnt_q, hot_cnt_d;
  status_e          status_q, status_d;
  logic             ev_valid_q, ev_valid_d;
  logic [PageW-1:0] ev_page_q, ev_page_d;
  logic             found_q, found_d;

  logic             cold_we, hot_we;
  logic [CAW-1:0]   cold_waddr;
  logic [HAW-1:0]   hot_waddr;
  logic [PageW-1:0] cold_wdata, hot_wdata;
  logic [PageW-1:0] cold_rdata, hot_rdata, rdata;
  logic             accept, cold_full, hot_full, data_hit;

  tspr_ram #(.Depth(COLD_DEPTH), .Width(PageW)) u_cold_ram (
    .clk_i   (clk_i),
    .we_i    (cold_we),
    .waddr_i (cold_waddr),
    .wdata_i (cold_wdata),
    .raddr_i (rd_idx_q[CAW-1:0]),
    .rdata_o (cold_rdata)
  );

  tspr_ram #(.Depth(HOT_DEPTH), .Width(PageW)) u_hot_ram (
    .clk_i   (clk_i),
    .we_i    (hot_we),
    .waddr_i (hot_waddr),
    .wdata_i (hot_wdata),
    .raddr_i (rd_idx_q[HAW-1:0]),
    .rdata_o (hot_rdata)
  );

  assign req_ready_o = (state_q == S_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign cold_full   = (cold_cnt_q == CCW'(COLD_DEPTH));
  assign hot_full    = (hot_cnt_q == HCW'(HOT_DEPTH));
  assign rdata       = sel_hot_q ? hot_rdata : cold_rdata;
  assign data_hit    = (rdata == id_q);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    id_d       = id_q;
    sel_hot_d  = sel_hot_q;
    down_d     = down_q;
    rd_idx_d   = rd_idx_q;
    rem_d      = rem_q;
    rv_d       = 1'b0;
    ra_d       = rd_idx_q;
    w_d        = w_q;
    cold_cnt_d = cold_cnt_q;
    hot_cnt_d  = hot_cnt_q;
    status_d   = status_q;
    ev_valid_d = ev_valid_q;
    ev_page_d  = ev_page_q;
    found_d    = found_q;
    cold_we    = 1'b0;
    cold_waddr = '0;
    cold_wdata = id_q;
    hot_we     = 1'b0;
    hot_waddr  = '0;
    hot_wdata  = id_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d    = S_SWEEP;
          id_d       = page_id_i;
          op_d       = OP_NONE;
          ev_valid_d = 1'b0;
          ev_page_d  = '0;
          found_d    = 1'b0;
          w_d        = '0;
          sel_hot_d  = 1'b0;
          down_d     = 1'b1;
          rd_idx_d   = '0;
          rem_d      = '0;
          if (page_absent_i) begin
            status_d = ST_NULL;
          end else if (action_i == ACT_INSERT) begin
            if (!cold_full) begin
              op_d     = OP_COLD_APPEND;
              status_d = ST_COLD_APPEND;
            end else if (!hot_full) begin
              op_d      = OP_HOT_PUSH;
              status_d  = ST_HOT_PUSH;
              sel_hot_d = 1'b1;
              rd_idx_d  = AW'(hot_cnt_q) - AW'(1);
              rem_d     = RW'(hot_cnt_q);
            end else begin
              op_d     = OP_COLD_REPLACE;
              status_d = ST_COLD_REPLACE;
              rd_idx_d = AW'(COLD_DEPTH - 1);
              rem_d    = RW'(COLD_DEPTH - ColdLo);
            end
          end else begin
            if (!cold_full) begin
              status_d = ST_COLD_NOT_FULL;
            end else if (hot_full) begin
              status_d = ST_HOT_FULL;
            end else begin
              op_d     = OP_PROMOTE;
              status_d = ST_PROMOTED;
              down_d   = 1'b0;
              rem_d    = RW'(COLD_DEPTH);
            end
          end
        end
      end

      S_SWEEP: begin
        if (rem_q != '0) begin
          rv_d     = 1'b1;
          rem_d    = rem_q - RW'(1);
          rd_idx_d = down_q ? (rd_idx_q - AW'(1)) : (rd_idx_q + AW'(1));
        end
        if (rv_q) begin
          if (down_q) begin
            if (op_q == OP_COLD_REPLACE && ra_q == AW'(COLD_DEPTH - 1)) begin
              ev_valid_d = 1'b1;
              ev_page_d  = rdata;
            end else if (sel_hot_q) begin
              hot_we    = 1'b1;
              hot_waddr = HAW'(ra_q + AW'(1));
              hot_wdata = rdata;
            end else begin
              cold_we    = 1'b1;
              cold_waddr = CAW'(ra_q + AW'(1));
              cold_wdata = rdata;
            end
          end else if (data_hit) begin
            found_d = 1'b1;
          end else begin
            cold_we    = 1'b1;
            cold_waddr = CAW'(w_q);
            cold_wdata = rdata;
            w_d        = w_q + CCW'(1);
          end
        end
        if (rem_q == '0) begin
          if (op_q == OP_PROMOTE && !sel_hot_q) begin
            sel_hot_d = 1'b1;
            down_d    = 1'b1;
            rd_idx_d  = AW'(hot_cnt_q) - AW'(1);
            rem_d     = RW'(hot_cnt_q);
          end else begin
            state_d = S_FINAL;
          end
        end
      end

      S_FINAL: begin
        state_d = S_DONE;
        case (op_q)
          OP_COLD_APPEND: begin
            cold_we    = 1'b1;
            cold_waddr = CAW'(cold_cnt_q);
            cold_cnt_d = cold_cnt_q + CCW'(1);
          end
          OP_HOT_PUSH: begin
            hot_we    = 1'b1;
            hot_cnt_d = hot_cnt_q + HCW'(1);
          end
          OP_COLD_REPLACE: begin
            cold_we    = 1'b1;
            cold_waddr = CAW'(ColdLo);
          end
          OP_PROMOTE: begin
            hot_we     = 1'b1;
            hot_cnt_d  = hot_cnt_q + HCW'(1);
            cold_cnt_d = w_q;
          end
          default: begin
          end
        endcase
      end

      S_DONE: begin
        if (rslt_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      op_q       <= OP_NONE;
      sel_hot_q  <= 1'b0;
      down_q     <= 1'b1;
      rem_q      <= '0;
      rv_q       <= 1'b0;
      cold_cnt_q <= '0;
      hot_cnt_q  <= '0;
    end else begin
      state_q    <= state_d;
      op_q       <= op_d;
      sel_hot_q  <= sel_hot_d;
      down_q     <= down_d;
      rem_q      <= rem_d;
      rv_q       <= rv_d;
      cold_cnt_q <= cold_cnt_d;
      hot_cnt_q  <= hot_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q       <= id_d;
    rd_idx_q   <= rd_idx_d;
    ra_q       <= ra_d;
    w_q        <= w_d;
    status_q   <= status_d;
    ev_valid_q <= ev_valid_d;
    ev_page_q  <= ev_page_d;
    found_q    <= found_d;
  end

  assign rslt_valid_o         = (state_q == S_DONE);
  assign rslt_o.status        = status_q;
  assign rslt_o.evicted_valid = ev_valid_q;
  assign rslt_o.evicted_page  = ev_page_q;
  assign rslt_o.found_in_cold = found_q;

endmodule

`default_nettype wire

[rtl/core/tspr_checker.sv]
// Port-level assertions for the page replacement core, with the bind that attaches them.
// Depends on tspr_pkg and two_segment_page_replacement_core.
`default_nettype none

module tspr_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic [2:0]                 status_i,
  input logic                       evicted_valid_i,
  input logic [tspr_pkg::PageW-1:0] evicted_page_i,
  input logic                       found_in_cold_i
);
  import tspr_pkg::*;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i))
    else $error("Response transaction changed while stalled.");

  a_evict_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (evicted_valid_i == (status_i == ST_COLD_REPLACE)))
    else $error("Eviction flag disagrees with status.");

  a_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !evicted_valid_i |-> (evicted_page_i == '0))
    else $error("Evicted page is nonzero without an eviction.");

  a_found_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && found_in_cold_i |-> (status_i == ST_PROMOTED))
    else $error("Found flag set on a response that is not a promote.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("Request accepted while the previous one is still in work.");

endmodule

bind two_segment_page_replacement_core tspr_checker u_tspr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .status_i        (rsp_o.status),
  .evicted_valid_i (rsp_o.evicted_valid),
  .evicted_page_i  (rsp_o.evicted_page),
  .found_in_cold_i (rsp_o.found_in_cold)
);

`default_nettype wire
